FILE: design/qpd_pkg.sv
// qpd_pkg: shared types, character constants and hex helper for the
// quoted-printable decoder core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qpd_pkg;

	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam int MAX_RES = 3;

	typedef enum logic [1:0] {
		PH_NONE    = 2'd0,
		PH_EQ      = 2'd1,
		PH_EQ_CHAR = 2'd2
	} qpd_phase_t;

	// results caused by one input byte
	typedef struct packed {
		logic [1:0]                  count;
		logic [MAX_RES-1:0][7:0]     data;
		logic [MAX_RES-1:0]          valid;
		logic                        stream_end;
	} qpd_res_t;

	// returns {is_hex, nibble}
	function automatic logic [4:0] hex_decode(logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/qpd_decode.sv
// qpd_decode: combinational decode of one byte against the hold state,
// giving up to three results and the next hold state. Depends on qpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qpd_decode (
	input  wire logic               mode,
	input  wire logic [7:0]         in_byte,
	input  wire logic               last_byte,
	input  wire qpd_pkg::qpd_phase_t phase,
	input  wire logic [7:0]         held,
	output qpd_pkg::qpd_res_t       res,
	output qpd_pkg::qpd_phase_t     phase_next,
	output logic [7:0]              held_next
);

	function automatic qpd_pkg::qpd_res_t push(qpd_pkg::qpd_res_t r, logic [7:0] b,
			logic v);
		qpd_pkg::qpd_res_t o;
		o = r;
		o.data[r.count] = b;
		o.valid[r.count] = v;
		o.count = r.count + 2'd1;
		return o;
	endfunction

	function automatic qpd_pkg::qpd_res_t flush(qpd_pkg::qpd_res_t r,
			qpd_pkg::qpd_phase_t ph, logic [7:0] hc);
		qpd_pkg::qpd_res_t o;
		o = r;
		if (ph == qpd_pkg::PH_EQ || ph == qpd_pkg::PH_EQ_CHAR) begin
			o = push(o, qpd_pkg::CH_EQ, 1'b1);
		end
		if (ph == qpd_pkg::PH_EQ_CHAR) begin
			o = push(o, hc, 1'b1);
		end
		return o;
	endfunction

	always_comb begin
		qpd_pkg::qpd_res_t   r;
		qpd_pkg::qpd_phase_t ph;
		logic [7:0]          hc;
		logic [4:0]          hx_hi;
		logic [4:0]          hx_lo;
		r = '0;
		ph = phase;
		hc = held;
		hx_hi = qpd_pkg::hex_decode(held);
		hx_lo = qpd_pkg::hex_decode(in_byte);
		if (ph != qpd_pkg::PH_EQ && ph != qpd_pkg::PH_EQ_CHAR) begin
			ph = qpd_pkg::PH_NONE;
		end
		if (!mode) begin
			r = flush(r, ph, hc);
			ph = qpd_pkg::PH_NONE;
			hc = '0;
			r = push(r, in_byte, 1'b1);
		end else begin
			if (ph == qpd_pkg::PH_EQ_CHAR) begin
				if (held == qpd_pkg::CH_CR && in_byte == qpd_pkg::CH_LF) begin
					ph = qpd_pkg::PH_NONE;
					hc = '0;
				end else if (hx_hi[4] && hx_lo[4]) begin
					r = push(r, {hx_hi[3:0], hx_lo[3:0]}, 1'b1);
					ph = qpd_pkg::PH_NONE;
					hc = '0;
				end else begin
					r = flush(r, ph, hc);
					ph = qpd_pkg::PH_NONE;
					hc = '0;
				end
			end else if (ph == qpd_pkg::PH_EQ) begin
				if (in_byte == qpd_pkg::CH_CR || hx_lo[4]) begin
					ph = qpd_pkg::PH_EQ_CHAR;
					hc = in_byte;
				end else begin
					r = flush(r, ph, hc);
					ph = qpd_pkg::PH_NONE;
					hc = '0;
				end
			end
			// plain byte handling when nothing is (any longer) held
			if (ph == qpd_pkg::PH_NONE &&
					!(phase == qpd_pkg::PH_EQ_CHAR && held == qpd_pkg::CH_CR &&
					in_byte == qpd_pkg::CH_LF) &&
					!(phase == qpd_pkg::PH_EQ_CHAR && hx_hi[4] && hx_lo[4])) begin
				if (in_byte == qpd_pkg::CH_EQ) begin
					ph = qpd_pkg::PH_EQ;
					hc = '0;
				end else begin
					r = push(r, in_byte, 1'b1);
				end
			end
		end
		if (last_byte) begin
			r = flush(r, ph, hc);
			ph = qpd_pkg::PH_NONE;
			hc = '0;
			if (r.count == 2'd0) begin
				r = push(r, 8'h00, 1'b0);
			end
			r.stream_end = 1'b1;
		end
		res = r;
		phase_next = ph;
		held_next = hc;
	end

endmodule
`default_nettype wire

FILE: design/qpd_emitter.sv
// qpd_emitter: result buffer that holds the results of one byte and sends
// them out one transfer per cycle while m_tready is high. Depends on qpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qpd_emitter (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire qpd_pkg::qpd_res_t res_in,
	output logic                   free,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [7:0]             m_tdata,
	output logic [1:0]             m_tuser,
	output logic                   m_tlast
);

	qpd_pkg::qpd_res_t buf_q;
	logic [1:0]        idx_q;
	logic              full_q;
	logic              is_last;
	logic              take;

	assign is_last = (idx_q == buf_q.count - 2'd1);
	assign take = full_q && m_tready;
	assign free = !full_q || (take && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			full_q <= 1'b1;
			idx_q <= '0;
		end else if (take) begin
			if (is_last) begin
				full_q <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res_in;
		end
	end

	assign m_tvalid = full_q;
	assign m_tdata = buf_q.data[idx_q];
	assign m_tuser = {is_last, buf_q.valid[idx_q]};
	assign m_tlast = is_last && buf_q.stream_end;

endmodule
`default_nettype wire

FILE: design/quoted_printable_decoder_core.sv
// quoted_printable_decoder_core: top level with input register, hold state,
// mode register and result emitter. Depends on qpd_pkg, qpd_decode, qpd_emitter.
//
// Usage:
//  - s_* channel takes one encoded byte per transfer; s_tlast marks the end of
//    the body. m_* channel gives decoded results, one per transfer.
//  - m_tuser[0] is byte_valid (0 only for a bare end marker), m_tuser[1] is
//    run_last (last result of its input byte), m_tlast is stream_end.
//  - cfg_valid/cfg_data write decode_mode (1 decode, 0 copy); write only when
//    the block is idle. cfg_ready is always high.
//  - the first result of a byte is presented from the result buffer, which
//    loads it from the input register once the buffer is free.
//  - throughput: one byte per cycle while each byte yields at most one
//    result and m_tready is high; a byte with several results holds the
//    result buffer while the output side sends them, one result per cycle.
//  - bytes that yield nothing (held '=' and escape bytes) pass the input
//    register without waiting on the result buffer.
//  - reset clears the hold state, empties both registers and sets decode mode.
//  - when m_tready is low the current result holds; one more byte waits in
//    the input register, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module quoted_printable_decoder_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data,   // decode_mode
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,    // in_byte
	input  wire logic       s_tlast,    // last_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,    // out_byte
	output logic [1:0]      m_tuser,    // [0] byte_valid, [1] run_last
	output logic            m_tlast     // stream_end
);

	logic                mode_q;
	qpd_pkg::qpd_phase_t phase_q;
	logic [7:0]          held_q;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;

	qpd_pkg::qpd_res_t   res;
	qpd_pkg::qpd_phase_t phase_next;
	logic [7:0]          held_next;
	logic                free;
	logic                advance;
	logic                load;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (res.count == 2'd0 || free);
	assign load = advance && res.count != 2'd0;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
			phase_q <= qpd_pkg::PH_NONE;
			held_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (advance) begin
				phase_q <= phase_next;
				held_q <= held_next;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	qpd_decode u_decode (
		.mode       (mode_q),
		.in_byte    (byte_s1),
		.last_byte  (last_s1),
		.phase      (phase_q),
		.held       (held_q),
		.res        (res),
		.phase_next (phase_next),
		.held_next  (held_next)
	);

	qpd_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res_in   (res),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

FILE: tb/qpd_checker.sv
// qpd_checker: watches the config, input and result channels of the quoted-printable
// decoder, predicts every result and compares it field by field. Depends on qpd_pkg.
`timescale 1ns / 1ps
module qpd_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic       cfg_data,
	input  wire logic       s_tvalid,
	input  wire logic       s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       s_tlast,
	input  wire logic       m_tvalid,
	input  wire logic       m_tready,
	input  wire logic [7:0] m_tdata,
	input  wire logic [1:0] m_tuser,
	input  wire logic       m_tlast,
	output int              fails,
	output int              pending
);

	typedef struct packed {
		logic [7:0] data;
		logic       vld;
		logic       run_last;
		logic       s_end;
	} qp_result_t;

	qp_result_t want_q[$];
	qp_result_t step_q[$];

	logic                decode_on;
	qpd_pkg::qpd_phase_t hold;
	logic [7:0]          held;

	function automatic int nibble_of(input logic [7:0] c);
		if (c inside {[8'h30:8'h39]}) begin
			return int'(c) - 'h30;
		end
		if (c inside {[8'h41:8'h46]}) begin
			return int'(c) - 'h41 + 10;
		end
		if (c inside {[8'h61:8'h66]}) begin
			return int'(c) - 'h61 + 10;
		end
		return -1;
	endfunction

	task automatic put_byte(input logic [7:0] b, input logic vld);
		qp_result_t r;
		r = '{data: b, vld: vld, run_last: 1'b0, s_end: 1'b0};
		step_q.push_back(r);
	endtask

	task automatic release_hold();
		if (hold == qpd_pkg::PH_EQ || hold == qpd_pkg::PH_EQ_CHAR) begin
			put_byte(qpd_pkg::CH_EQ, 1'b1);
		end
		if (hold == qpd_pkg::PH_EQ_CHAR) begin
			put_byte(held, 1'b1);
		end
		hold = qpd_pkg::PH_NONE;
		held = '0;
	endtask

	task automatic literal_or_escape(input logic [7:0] b);
		if (b == qpd_pkg::CH_EQ) begin
			hold = qpd_pkg::PH_EQ;
			held = '0;
		end else begin
			put_byte(b, 1'b1);
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic last);
		int hi;
		int lo;
		hi = nibble_of(held);
		lo = nibble_of(b);
		if (!decode_on) begin
			release_hold();
			put_byte(b, 1'b1);
		end else if (hold == qpd_pkg::PH_EQ_CHAR) begin
			if (held == qpd_pkg::CH_CR && b == qpd_pkg::CH_LF) begin
				hold = qpd_pkg::PH_NONE;
				held = '0;
			end else if (hi >= 0 && lo >= 0) begin
				put_byte(8'(hi * 16 + lo), 1'b1);
				hold = qpd_pkg::PH_NONE;
				held = '0;
			end else begin
				release_hold();
				literal_or_escape(b);
			end
		end else if (hold == qpd_pkg::PH_EQ) begin
			if (b == qpd_pkg::CH_CR || lo >= 0) begin
				hold = qpd_pkg::PH_EQ_CHAR;
				held = b;
			end else begin
				release_hold();
				literal_or_escape(b);
			end
		end else begin
			literal_or_escape(b);
		end
		if (last) begin
			release_hold();
			if (step_q.size() == 0) begin
				put_byte(8'h00, 1'b0);
			end
			step_q[step_q.size()-1].s_end = 1'b1;
		end
		if (step_q.size() > 0) begin
			step_q[step_q.size()-1].run_last = 1'b1;
		end
		foreach (step_q[i]) begin
			want_q.push_back(step_q[i]);
		end
		step_q.delete();
	endtask

	task automatic note_fail(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		qp_result_t w;
		if (!arst_n) begin
			decode_on = 1'b1;
			hold = qpd_pkg::PH_NONE;
			held = '0;
			want_q.delete();
			fails = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (want_q.size() == 0) begin
					note_fail("unexpected result, out_byte", m_tdata, 0);
				end else begin
					w = want_q.pop_front();
					if (m_tdata !== w.data) begin
						note_fail("out_byte", m_tdata, w.data);
					end
					if (m_tuser[0] !== w.vld) begin
						note_fail("byte_valid", m_tuser[0], w.vld);
					end
					if (m_tuser[1] !== w.run_last) begin
						note_fail("run_last", m_tuser[1], w.run_last);
					end
					if (m_tlast !== w.s_end) begin
						note_fail("stream_end", m_tlast, w.s_end);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				decode_on = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, s_tlast);
			end
			pending <= want_q.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
// tb_top: stimulus and verdict for quoted_printable_decoder_core; directed escapes,
// soft breaks and end-of-stream flushes, then random streams under both modes.
// Depends on qpd_pkg, the core and qpd_checker.
`timescale 1ns / 1ps
module tb_top;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;
	int         fails;
	int         pending;
	int         tx_idle_pct = 0;
	int         rx_idle_pct = 0;
	int         sent = 0;

	quoted_printable_decoder_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	qpd_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.fails(fails),
		.pending(pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic push(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_mode(input logic v);
		wait_drained();
		repeat (6) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] any_hex_digit();
		int n;
		n = $urandom_range(21);
		if (n < 10) begin
			return 8'(8'h30 + n);
		end
		if (n < 16) begin
			return 8'(8'h41 + n - 10);
		end
		return 8'(8'h61 + n - 16);
	endfunction

	function automatic logic end_mark();
		return ($urandom_range(15) == 0);
	endfunction

	// plain bytes, well-formed escapes and soft breaks, plus broken escapes and noise
	task automatic random_chunk();
		int k;
		logic [7:0] b;
		k = $urandom_range(99);
		if (k < 30) begin
			repeat ($urandom_range(3, 1)) begin
				b = 8'($urandom_range(255));
				if (b == qpd_pkg::CH_EQ) begin
					b = 8'h7E;
				end
				push(b, end_mark());
			end
		end else if (k < 60) begin
			push(qpd_pkg::CH_EQ, 1'b0);
			push(any_hex_digit(), 1'b0);
			push(any_hex_digit(), end_mark());
		end else if (k < 70) begin
			push(qpd_pkg::CH_EQ, 1'b0);
			push(qpd_pkg::CH_CR, 1'b0);
			push(qpd_pkg::CH_LF, end_mark());
		end else if (k < 80) begin
			push(qpd_pkg::CH_EQ, end_mark());
			push(8'($urandom_range(255)), end_mark());
		end else if (k < 88) begin
			push(qpd_pkg::CH_EQ, 1'b0);
			push(($urandom_range(1) != 0) ? qpd_pkg::CH_CR : any_hex_digit(), end_mark());
			push(8'($urandom_range(255)), end_mark());
		end else begin
			push(8'($urandom_range(255)), end_mark());
		end
	endtask

	task automatic random_stream(input int count);
		int stop_at;
		stop_at = sent + count;
		while (sent < stop_at) begin
			random_chunk();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_pct <= 25;
		rx_idle_pct <= 70;
		write_mode(1'b1);

		// hex escape in both letter cases
		push(qpd_pkg::CH_EQ, 1'b0);
		push("f", 1'b0);
		push("F", 1'b0);
		// soft break
		push(qpd_pkg::CH_EQ, 1'b0);
		push(qpd_pkg::CH_CR, 1'b0);
		push(qpd_pkg::CH_LF, 1'b0);
		// bad escape passes literally
		push(qpd_pkg::CH_EQ, 1'b0);
		push("G", 1'b0);
		// second equals starts a new escape
		push(qpd_pkg::CH_EQ, 1'b0);
		push(qpd_pkg::CH_EQ, 1'b0);
		push("4", 1'b0);
		push("1", 1'b0);
		// CR not followed by LF
		push(qpd_pkg::CH_EQ, 1'b0);
		push(qpd_pkg::CH_CR, 1'b0);
		push("x", 1'b0);
		push(8'h00, 1'b0);
		push(8'hFF, 1'b0);
		// three results from one byte at end of stream
		push(qpd_pkg::CH_EQ, 1'b0);
		push("4", 1'b0);
		push(qpd_pkg::CH_EQ, 1'b1);
		// soft break ending the stream gives a bare end marker
		push(qpd_pkg::CH_EQ, 1'b0);
		push(qpd_pkg::CH_CR, 1'b0);
		push(qpd_pkg::CH_LF, 1'b1);

		random_stream(40);
		push(qpd_pkg::CH_EQ, 1'b0);
		tx_idle_pct <= 70;
		rx_idle_pct <= 25;
		write_mode(1'b1);

		random_stream(35);
		push(qpd_pkg::CH_EQ, 1'b0);
		push("4", 1'b0);
		write_mode(1'b0);

		random_stream(25);
		tx_idle_pct <= 0;
		rx_idle_pct <= 0;
		write_mode(1'b1);

		random_stream(30);
		push("z", 1'b1);
		wait_drained();
		repeat (10) @(posedge clk);
		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
